FILE: rtl/core/rrts_pkg.sv
package rrts_pkg;

  localparam int NumTasks = 16;
  localparam int TaskW = $clog2(NumTasks);
  localparam int CntW = $clog2(NumTasks + 1);
  localparam logic [7:0] QuantumAtReset = 8'd5;

  typedef enum logic [1:0] {
    MODE_READY   = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_SLEEP   = 2'd2,
    MODE_DONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_RAN    = 2'd0,
    KIND_IO     = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_OTHER  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_REPORT,
    ST_REFILL,
    ST_DISPATCH,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic sweep;
    logic report;
    logic pop;
    logic clear_idx;
    logic check_refill;
    logic start_disp;
    logic finish;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic idx_last;
    logic disp_need;
    logic disp_done;
  } stat_t;

endpackage

FILE: rtl/core/round_robin_task_scheduler_unit.sv
// channel | direction | handshake           | payload
// cfg     | in        | cfg_valid/cfg_ready  | cfg_time_quantum
// in      | in        | in_valid/in_stall    | in_cmd .. in_task_index
// out     | out       | out_valid/out_stall  | out_running_valid .. out_wait_total
// a tick steps through the per-entry sweep, the running task report, the quantum
// scan with refill and up to NUM_TASKS queue pops; a read goes from the sweep to the result.
// one word in flight; the next is taken once the result is accepted.
// reset is synchronous; all tasks ready and queued, quantum 5.
module round_robin_task_scheduler_unit import rrts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_time_quantum,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic        in_report_valid,
  input  logic [1:0]  in_report_kind,
  input  logic [3:0]  in_io_wait_ticks,
  input  logic [3:0]  in_task_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_running_valid,
  output logic [3:0]  out_running_task,
  output logic        out_newly_dispatched,
  output logic        out_idle_tick,
  output logic        out_quantum_refilled,
  output logic [4:0]  out_live_count,
  output logic        out_all_finished,
  output logic [31:0] out_wait_total
);

  ctrl_t ctl;
  stat_t st;

  assign cfg_ready = 1'b1;

  rrts_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .st, .ctl
  );

  rrts_dp u_dp (
    .clk, .rst_n, .ctl, .st, .cfg_valid, .cfg_ready, .cfg_time_quantum,
    .in_cmd, .in_report_valid, .in_report_kind, .in_io_wait_ticks, .in_task_index,
    .out_running_valid, .out_running_task, .out_newly_dispatched, .out_idle_tick,
    .out_quantum_refilled, .out_live_count, .out_all_finished, .out_wait_total
  );

endmodule

FILE: rtl/core/rrts_ctrl.sv
module rrts_ctrl import rrts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t st,
  output ctrl_t ctl
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (st.is_read) begin
          ctl.finish = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          ctl.sweep = 1'b1;
          if (st.idx_last) begin
            state_nxt = ST_REPORT;
          end
        end
      end
      ST_REPORT: begin
        ctl.report = 1'b1;
        ctl.clear_idx = 1'b1;
        state_nxt = ST_REFILL;
      end
      ST_REFILL: begin
        ctl.check_refill = 1'b1;
        if (st.idx_last) begin
          ctl.start_disp = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!st.disp_need || st.disp_done) begin
          ctl.finish = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          ctl.pop = 1'b1;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/rrts_dp.sv
module rrts_dp import rrts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_t       ctl,
  output stat_t       st,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_time_quantum,
  input  logic        in_cmd,
  input  logic        in_report_valid,
  input  logic [1:0]  in_report_kind,
  input  logic [3:0]  in_io_wait_ticks,
  input  logic [3:0]  in_task_index,
  output logic        out_running_valid,
  output logic [3:0]  out_running_task,
  output logic        out_newly_dispatched,
  output logic        out_idle_tick,
  output logic        out_quantum_refilled,
  output logic [4:0]  out_live_count,
  output logic        out_all_finished,
  output logic [31:0] out_wait_total
);

  logic [7:0] tq_r;
  mode_t      mode_r [NumTasks];
  logic [7:0] qleft_r [NumTasks];
  logic [3:0] ioc_r [NumTasks];
  logic [31:0] wsum_r [NumTasks];
  logic [NumTasks-1:0] queued_r;
  logic [TaskW-1:0] slot_r [NumTasks];
  logic [TaskW-1:0] head_r, tail_r;
  logic [CntW-1:0] fill_r, alive_r, tries_r;
  logic [TaskW-1:0] cur_r, idx_r;
  logic cur_v_r, any_left_r, disp_r, idle_r, refil_r;
  logic cmd_r, rv_r;
  logic [1:0] kind_r;
  logic [3:0] iow_r, tidx_r;
  logic [31:0] wout_r;

  // push logic shared by sweep, report and dispatch (one push per cycle)
  logic push;
  logic [TaskW-1:0] push_t;
  logic pop_ok;
  logic [TaskW-1:0] pop_t;
  logic [CntW-1:0] fill_dec;

  assign pop_t = slot_r[head_r];
  assign pop_ok = ctl.pop && fill_r != '0 && tries_r != '0;
  assign fill_dec = fill_r - {{(CntW-1){1'b0}}, pop_ok};

  always_comb begin
    push = 1'b0;
    push_t = idx_r;
    if (ctl.sweep) begin
      push = mode_r[idx_r] == MODE_SLEEP && ioc_r[idx_r] <= 4'd1 && !queued_r[idx_r];
      push_t = idx_r;
    end else if (ctl.report) begin
      push = cur_v_r && rv_r && kind_r != KIND_IO && kind_r != KIND_FINISH
             && qleft_r[cur_r] <= 8'd1 && !queued_r[cur_r];
      push_t = cur_r;
    end else if (pop_ok) begin
      push = mode_r[pop_t] == MODE_READY && qleft_r[pop_t] == 8'd0;
      push_t = pop_t;
    end
  end

  assign st.is_read = cmd_r;
  assign st.idx_last = idx_r == TaskW'(NumTasks - 1);
  assign st.disp_need = !cur_v_r && alive_r != '0;
  assign st.disp_done = disp_r || fill_r == '0 || tries_r == '0;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tq_r <= QuantumAtReset;
    end else if (cfg_valid && cfg_ready) begin
      tq_r <= cfg_time_quantum;
    end
  end

  // task tables, queue and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumTasks; i++) begin
        mode_r[i] <= MODE_READY;
        qleft_r[i] <= QuantumAtReset;
        ioc_r[i] <= '0;
        wsum_r[i] <= '0;
        slot_r[i] <= TaskW'(i);
      end
      queued_r <= '1;
      head_r <= '0;
      tail_r <= '0;
      fill_r <= CntW'(NumTasks);
      alive_r <= CntW'(NumTasks);
      cur_r <= '0;
      cur_v_r <= 1'b0;
      idx_r <= '0;
      tries_r <= '0;
      any_left_r <= 1'b0;
      disp_r <= 1'b0;
      idle_r <= 1'b0;
      refil_r <= 1'b0;
      cmd_r <= 1'b0;
    end else begin
      if (ctl.load) begin
        cmd_r <= in_cmd;
        rv_r <= in_report_valid;
        kind_r <= in_report_kind;
        iow_r <= in_io_wait_ticks;
        tidx_r <= in_task_index;
        idx_r <= '0;
        disp_r <= 1'b0;
        idle_r <= 1'b0;
        refil_r <= 1'b0;
        any_left_r <= 1'b0;
      end
      // one entry per cycle: wake sleepers, count ready wait
      if (ctl.sweep) begin
        idx_r <= idx_r + 1'b1;
        if (mode_r[idx_r] == MODE_SLEEP) begin
          if (ioc_r[idx_r] <= 4'd1) begin
            ioc_r[idx_r] <= '0;
            mode_r[idx_r] <= MODE_READY;
          end else begin
            ioc_r[idx_r] <= ioc_r[idx_r] - 4'd1;
          end
        end else if (mode_r[idx_r] == MODE_READY && wsum_r[idx_r] != '1) begin
          wsum_r[idx_r] <= wsum_r[idx_r] + 32'd1;
        end
      end
      if (ctl.clear_idx) begin
        idx_r <= '0;
      end
      // running task report
      if (ctl.report && cur_v_r && rv_r) begin
        if (qleft_r[cur_r] != 8'd0) begin
          qleft_r[cur_r] <= qleft_r[cur_r] - 8'd1;
        end
        if (kind_r == KIND_FINISH) begin
          mode_r[cur_r] <= MODE_DONE;
          if (alive_r != '0) alive_r <= alive_r - 1'b1;
          cur_v_r <= 1'b0;
        end else if (kind_r == KIND_IO) begin
          mode_r[cur_r] <= MODE_SLEEP;
          ioc_r[cur_r] <= iow_r;
          cur_v_r <= 1'b0;
        end else if (qleft_r[cur_r] <= 8'd1) begin
          mode_r[cur_r] <= MODE_READY;
          cur_v_r <= 1'b0;
        end
      end
      // quantum scan, then refill on the last entry
      if (ctl.check_refill) begin
        idx_r <= idx_r + 1'b1;
        if (ctl.start_disp) begin
          tries_r <= fill_r;
          if (!(any_left_r || ((mode_r[idx_r] == MODE_READY || mode_r[idx_r] == MODE_RUNNING)
                               && qleft_r[idx_r] != 8'd0)) && alive_r != '0) begin
            refil_r <= 1'b1;
            for (int i = 0; i < NumTasks; i++) begin
              if (mode_r[i] != MODE_DONE) qleft_r[i] <= tq_r;
            end
          end
        end else if ((mode_r[idx_r] == MODE_READY || mode_r[idx_r] == MODE_RUNNING)
                     && qleft_r[idx_r] != 8'd0) begin
          any_left_r <= 1'b1;
        end
      end
      // dispatch pops
      if (pop_ok) begin
        head_r <= (head_r == TaskW'(NumTasks - 1)) ? '0 : head_r + 1'b1;
        queued_r[pop_t] <= 1'b0;
        tries_r <= tries_r - 1'b1;
        if (mode_r[pop_t] == MODE_READY && qleft_r[pop_t] != 8'd0) begin
          cur_r <= pop_t;
          cur_v_r <= 1'b1;
          mode_r[pop_t] <= MODE_RUNNING;
          disp_r <= 1'b1;
        end
      end
      fill_r <= fill_dec;
      if (push && fill_dec < CntW'(NumTasks)) begin
        slot_r[tail_r] <= push_t;
        tail_r <= (tail_r == TaskW'(NumTasks - 1)) ? '0 : tail_r + 1'b1;
        fill_r <= fill_dec + 1'b1;
        queued_r[push_t] <= 1'b1;
      end
      if (ctl.finish && !cmd_r && st.disp_need && !disp_r) begin
        idle_r <= 1'b1;
      end
    end
  end

  // read result
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      wout_r <= '0;
    end else if (ctl.finish && cmd_r) begin
      wout_r <= (32'(tidx_r) < NumTasks) ? wsum_r[TaskW'(tidx_r)] : '0;
    end
  end

  assign out_running_valid = cur_v_r;
  assign out_running_task = cur_v_r ? 4'(cur_r) : 4'd0;
  assign out_newly_dispatched = disp_r;
  assign out_idle_tick = idle_r;
  assign out_quantum_refilled = refil_r;
  assign out_live_count = 5'(alive_r);
  assign out_all_finished = alive_r == '0;
  assign out_wait_total = wout_r;

  // checks
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CntW'(NumTasks)) else $error("queue fill overflow");
  a_queued: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == 32'(fill_r)) else $error("queued marks disagree with fill");
  a_disp: assert property (@(posedge clk) disable iff (!rst_n)
    disp_r |-> cur_v_r) else $error("dispatch without running task");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(disp_r && idle_r)) else $error("idle and dispatch together");

endmodule
